// ===== rtl/core/mdiv_pkg.sv =====
// ----------------------------------------------------------------------------
// mdiv_pkg
// Shared types and constants for the multiword by word divider: payload
// widths, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package mdiv_pkg;

    localparam int DATA_BITS      = 64;
    localparam int WORD_BITS_DEF  = 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_ADD,
        S_RED,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic cfg_load;
        logic norm_step;
        logic load;
        logic add;
        logic reduce;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic dn_msb;
        logic d_zero;
        logic cnt_zero;
    } t_stat;

endpackage

// ===== rtl/core/mdiv_intf.sv =====
// ----------------------------------------------------------------------------
// mdiv channel interfaces
// Valid/ready channels for dividend words, results and divisor writes.
// ----------------------------------------------------------------------------
interface mdiv_in_if;
    logic                           valid;
    logic                           ready;
    logic [mdiv_pkg::DATA_BITS-1:0] dividend_word;
    logic                           final_word;

    modport source (output valid, output dividend_word, output final_word, input ready);
    modport sink   (input valid, input dividend_word, input final_word, output ready);
endinterface

interface mdiv_out_if;
    logic                           valid;
    logic                           ready;
    logic [mdiv_pkg::DATA_BITS-1:0] quotient_word;
    logic [mdiv_pkg::DATA_BITS-1:0] remainder_word;
    logic                           result_last;

    modport source (output valid, output quotient_word, output remainder_word,
                    output result_last, input ready);
    modport sink   (input valid, input quotient_word, input remainder_word,
                    input result_last, output ready);
endinterface

interface mdiv_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mdiv_pkg::DATA_BITS-1:0] divisor;

    modport source (output valid, output divisor, input ready);
    modport sink   (input valid, input divisor, output ready);
endinterface

// ===== rtl/core/mdiv_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdiv_ctrl
// Controller: sequences divisor normalization, the per-word prepare steps,
// the bit-serial division and the hand-off into the output register.
// ----------------------------------------------------------------------------
module mdiv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mdiv_pkg::t_stat i_stat,
    output mdiv_pkg::t_cmd  o_cmd
);

    mdiv_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mdiv_pkg::S_IDLE: begin
                if (i_cfg_valid) begin
                    n_state = mdiv_pkg::S_NORM;
                end else if (i_in_valid) begin
                    // zero divisor needs no division
                    n_state = i_stat.d_zero ? mdiv_pkg::S_FIN : mdiv_pkg::S_ADD;
                end
            end
            mdiv_pkg::S_NORM: begin
                if (i_stat.dn_msb || i_stat.d_zero) begin
                    n_state = mdiv_pkg::S_IDLE;
                end
            end
            mdiv_pkg::S_ADD: n_state = mdiv_pkg::S_RED;
            mdiv_pkg::S_RED: n_state = mdiv_pkg::S_DIV;
            mdiv_pkg::S_DIV: begin
                if (i_stat.cnt_zero) begin
                    n_state = mdiv_pkg::S_FIN;
                end
            end
            mdiv_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = mdiv_pkg::S_IDLE;
                end
            end
            default: n_state = mdiv_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cfg_ready = 1'b0;
        o_in_ready  = 1'b0;
        case (r_state)
            mdiv_pkg::S_IDLE: begin
                o_cfg_ready    = 1'b1;
                // a divisor write takes precedence over a word
                o_in_ready     = !i_cfg_valid;
                o_cmd.cfg_load = i_cfg_valid;
                o_cmd.load     = !i_cfg_valid && i_in_valid;
            end
            mdiv_pkg::S_NORM: o_cmd.norm_step = !(i_stat.dn_msb || i_stat.d_zero);
            mdiv_pkg::S_ADD:  o_cmd.add       = 1'b1;
            mdiv_pkg::S_RED:  o_cmd.reduce    = 1'b1;
            mdiv_pkg::S_DIV:  o_cmd.div_step  = 1'b1;
            mdiv_pkg::S_FIN:  o_cmd.emit      = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mdiv_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/mdiv_dp.sv =====
// ----------------------------------------------------------------------------
// mdiv_dp
// Datapath: normalized divisor and shift, running remainder, the two-word
// working register with a one-bit-per-cycle restoring divide step, and the
// output register.
// ----------------------------------------------------------------------------
module mdiv_dp #(
    parameter int WORD_BITS = mdiv_pkg::WORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mdiv_pkg::t_cmd                 i_cmd,
    output mdiv_pkg::t_stat                o_stat,
    input  logic [mdiv_pkg::DATA_BITS-1:0] i_divisor,
    input  logic [mdiv_pkg::DATA_BITS-1:0] i_dividend_word,
    input  logic                           i_final_word,
    output logic [mdiv_pkg::DATA_BITS-1:0] o_quotient_word,
    output logic [mdiv_pkg::DATA_BITS-1:0] o_remainder_word,
    output logic                           o_result_last
);

    localparam int SW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0]   r_dn, n_dn;
    logic [SW-1:0]          r_shift, n_shift;
    logic                   r_dzero, n_dzero;
    logic [WORD_BITS-1:0]   r_rr, n_rr;
    logic [WORD_BITS-1:0]   r_hi, n_hi;
    logic [WORD_BITS-1:0]   r_lo, n_lo;
    logic                   r_last, n_last;
    logic [SW-1:0]          r_cnt, n_cnt;
    logic [WORD_BITS-1:0]   r_q, n_q;
    logic [WORD_BITS-1:0]   r_rem, n_rem;
    logic                   r_last_out, n_last_out;

    logic [WORD_BITS-1:0]   x_w;
    logic [WORD_BITS-1:0]   d_w;
    logic [2*WORD_BITS-1:0] x_wide;
    logic [WORD_BITS-1:0]   hi_step;
    logic                   take;

    assign x_w    = i_dividend_word[WORD_BITS-1:0];
    assign d_w    = i_divisor[WORD_BITS-1:0];
    assign x_wide = {{WORD_BITS{1'b0}}, x_w} << r_shift;

    // restoring step: the bit shifted out of hi forces a subtract
    assign hi_step = {r_hi[WORD_BITS-2:0], r_lo[WORD_BITS-1]};
    assign take    = r_hi[WORD_BITS-1] || (hi_step >= r_dn);

    always_comb begin
        n_dn       = r_dn;
        n_shift    = r_shift;
        n_dzero    = r_dzero;
        n_rr       = r_rr;
        n_hi       = r_hi;
        n_lo       = r_lo;
        n_last     = r_last;
        n_cnt      = r_cnt;
        n_q        = r_q;
        n_rem      = r_rem;
        n_last_out = r_last_out;

        if (i_cmd.cfg_load) begin
            n_dn    = d_w;
            n_shift = '0;
            n_dzero = (d_w == '0);
        end
        if (i_cmd.norm_step) begin
            n_dn    = r_dn << 1;
            n_shift = r_shift + SW'(1);
        end
        if (i_cmd.load) begin
            n_hi   = x_wide[2*WORD_BITS-1:WORD_BITS];
            n_lo   = x_wide[WORD_BITS-1:0];
            n_last = i_final_word;
        end
        if (i_cmd.add) begin
            n_hi = r_hi + r_rr;
        end
        if (i_cmd.reduce) begin
            // only after a divisor change in the middle of a number
            n_hi  = (r_hi >= r_dn) ? (r_hi - r_dn) : r_hi;
            n_cnt = SW'(WORD_BITS - 1);
        end
        if (i_cmd.div_step) begin
            n_hi  = take ? (hi_step - r_dn) : hi_step;
            n_lo  = {r_lo[WORD_BITS-2:0], take};
            n_cnt = r_cnt - SW'(1);
        end
        if (i_cmd.emit) begin
            n_q        = r_dzero ? {WORD_BITS{1'b1}} : r_lo;
            n_last_out = r_last;
            if (!r_last) begin
                n_rem = '0;
            end else if (r_dzero) begin
                n_rem = r_lo;
            end else begin
                n_rem = r_hi >> r_shift;
            end
            n_rr = (r_last || r_dzero) ? '0 : r_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // divisor 1 normalizes to the top bit
            r_dn    <= {1'b1, {(WORD_BITS-1){1'b0}}};
            r_shift <= SW'(WORD_BITS - 1);
            r_dzero <= 1'b0;
            r_rr    <= '0;
        end else begin
            r_dn    <= n_dn;
            r_shift <= n_shift;
            r_dzero <= n_dzero;
            r_rr    <= n_rr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi       <= n_hi;
        r_lo       <= n_lo;
        r_last     <= n_last;
        r_cnt      <= n_cnt;
        r_q        <= n_q;
        r_rem      <= n_rem;
        r_last_out <= n_last_out;
    end

    assign o_stat.dn_msb   = r_dn[WORD_BITS-1];
    assign o_stat.d_zero   = r_dzero;
    assign o_stat.cnt_zero = (r_cnt == '0);

    assign o_quotient_word  = mdiv_pkg::DATA_BITS'(r_q);
    assign o_remainder_word = mdiv_pkg::DATA_BITS'(r_rem);
    assign o_result_last    = r_last_out;

endmodule

// ===== rtl/core/multiword_by_word_divider_top.sv =====
// A word goes through the add, reduce, divide and finish states; a zero divisor skips
// to finish. Words are accepted only in idle; the divide step yields one bit per cycle.
// A divisor write is normalized before the next word is accepted.
// A new word is accepted while a previous result waits in the output register.
// Reset (synchronous, active low): divisor 1, running remainder 0, no result pending.
// ----------------------------------------------------------------------------
// multiword_by_word_divider_top
// Multi-word unsigned dividend, most significant word first, divided by a
// one-word divisor register; one quotient word per input word, remainder on
// the last word.
// ----------------------------------------------------------------------------
module multiword_by_word_divider_top #(
    parameter int WORD_BITS = mdiv_pkg::WORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mdiv_in_if.sink    i_in,
    mdiv_out_if.source o_out,
    mdiv_cfg_if.sink   i_cfg
);

    mdiv_pkg::t_cmd  cmd;
    mdiv_pkg::t_stat stat;

    mdiv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mdiv_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_divisor        (i_cfg.divisor),
        .i_dividend_word  (i_in.dividend_word),
        .i_final_word     (i_in.final_word),
        .o_quotient_word  (o_out.quotient_word),
        .o_remainder_word (o_out.remainder_word),
        .o_result_last    (o_out.result_last)
    );

endmodule
